@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock edge and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a consequent follows from an antecedent, as any property form.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ rtl/core/fan_gov_pkg.sv @@
`default_nettype none

package fan_gov_pkg;

   localparam int WINDOW_DEPTH_DEF = 8;
   localparam int TEMP_W           = 8;
   localparam int DUTY_W           = 7;
   localparam int STEP_COUNT       = 5;
   localparam int DIV_STEPS        = TEMP_W;

   // Thresholds in falling order; the first one not above the temperature wins.
   localparam logic [TEMP_W-1:0] STEP_TEMP [STEP_COUNT] =
      '{8'd50, 8'd49, 8'd48, 8'd47, 8'd46};
   localparam logic [DUTY_W-1:0] STEP_DUTY [STEP_COUNT] =
      '{7'd100, 7'd90, 7'd80, 7'd70, 7'd60};

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   function automatic logic [DUTY_W-1:0] duty_for(input logic [TEMP_W:0] temp,
                                                  input logic [DUTY_W-1:0] idle);
      logic [DUTY_W-1:0] duty;
      duty = idle;
      for (int k = STEP_COUNT - 1; k >= 0; k--) begin
         if (temp >= {1'b0, STEP_TEMP[k]}) begin
            duty = STEP_DUTY[k];
         end
      end
      return duty;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/windowed_temp_fan_duty_governor.sv @@
// Fan duty governor. Each item carries one peak temperature, which is written
// into a ring of the last WINDOW_DEPTH peaks held in a single-port synchronous
// memory; the filled part of the ring is then read back one entry per cycle,
// summed, and divided by the fill count in an eight-step shift-subtract
// divider. The average then drives the duty decision and exactly one result
// item (changed flag and duty) is produced per input item. An item's result is
// loaded into the output register after the ring read, a drain state that
// collects the last entry, the eight divider steps and the decision state. The
// next item is accepted in the cycle after the result has been loaded, even if
// that result has not yet been taken; a result still waiting in the output
// register holds the next one in its decision state.
// No clearing pass is needed after reset: only written ring entries are read.
`default_nettype none

module windowed_temp_fan_duty_governor #(
   parameter int WINDOW_DEPTH = fan_gov_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [fan_gov_pkg::TEMP_W-1:0]  req_peak_temp,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_changed,
   output logic [fan_gov_pkg::DUTY_W-1:0]  rsp_duty,
   input  wire                             csr_wr_en,
   input  wire  [fan_gov_pkg::DUTY_W-1:0]  csr_wr_data
);

`include "assert_macros.svh"

   localparam int TEMP_W = fan_gov_pkg::TEMP_W;
   localparam int DUTY_W = fan_gov_pkg::DUTY_W;
   localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = TEMP_W + CNT_W;
   localparam int DCNT_W = $clog2(fan_gov_pkg::DIV_STEPS);

   localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);
   localparam logic [DCNT_W-1:0] LAST_STEP = DCNT_W'(fan_gov_pkg::DIV_STEPS - 1);

   fan_gov_pkg::state_type state_ff, state_in;

   logic [DUTY_W-1:0] idle_duty_ff, idle_duty_in;
   logic [IDX_W-1:0]  write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [TEMP_W-1:0] prev_avg_ff, prev_avg_in;
   logic [1:0]        fall_streak_ff, fall_streak_in;
   logic [DUTY_W-1:0] held_duty_ff, held_duty_in;

   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              rd_vld_ff;
   logic [TEMP_W-1:0] rd_data_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [TEMP_W-1:0] quot_ff, quot_in;
   logic [DCNT_W-1:0] div_cnt_ff, div_cnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_changed_ff, rsp_changed_in;
   logic [DUTY_W-1:0] rsp_duty_ff, rsp_duty_in;

   logic [TEMP_W-1:0] peak_ring [WINDOW_DEPTH];

   logic              req_take;
   logic              rsp_take;
   logic              out_free;
   logic [SUM_W-1:0]  sum_total;
   logic [CNT_W:0]    trial;
   logic              trial_ge;
   logic [1:0]        streak_next;
   logic [TEMP_W:0]   avg_plus;

   assign req_take    = req_valid && !req_stall;
   assign rsp_take    = rsp_valid_ff && !rsp_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != fan_gov_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_changed = rsp_changed_ff;
   assign rsp_duty    = rsp_duty_ff;

   assign sum_total   = sum_ff + (rd_vld_ff ? SUM_W'(rd_data_ff) : SUM_W'(0));
   assign trial       = {rem_ff, quot_ff[TEMP_W-1]};
   assign trial_ge    = (trial >= {1'b0, fill_ff});
   assign streak_next = fall_streak_ff + 2'd1;
   assign avg_plus    = {1'b0, quot_ff} + {{TEMP_W{1'b0}}, 1'b1};

   // Ring memory: written on acceptance, read one entry a cycle while summing.
   always_ff @(posedge clock) begin
      if (req_take) begin
         peak_ring[write_slot_ff] <= req_peak_temp;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= peak_ring[rd_cnt_ff[IDX_W-1:0]];
   end

   always_comb begin
      state_in       = state_ff;
      idle_duty_in   = csr_wr_en ? csr_wr_data : idle_duty_ff;
      write_slot_in  = write_slot_ff;
      fill_in        = fill_ff;
      prev_avg_in    = prev_avg_ff;
      fall_streak_in = fall_streak_ff;
      held_duty_in   = held_duty_ff;
      rd_cnt_in      = rd_cnt_ff;
      sum_in         = sum_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;
      rsp_changed_in = rsp_changed_ff;
      rsp_duty_in    = rsp_duty_ff;

      unique case (state_ff)
         fan_gov_pkg::ST_IDLE: begin
            if (req_take) begin
               write_slot_in = (write_slot_ff == LAST_SLOT) ? '0 : write_slot_ff + IDX_W'(1);
               if (fill_ff != FULL_CNT) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               rd_cnt_in = '0;
               sum_in    = '0;
               state_in  = fan_gov_pkg::ST_READ;
            end
         end
         fan_gov_pkg::ST_READ: begin
            sum_in    = sum_total;
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
            if (rd_cnt_ff == fill_ff - CNT_W'(1)) begin
               state_in = fan_gov_pkg::ST_DRAIN;
            end
         end
         fan_gov_pkg::ST_DRAIN: begin
            // The high part of the sum is below the fill count, as the
            // average always fits in eight bits.
            rem_in     = sum_total[SUM_W-1:TEMP_W];
            quot_in    = sum_total[TEMP_W-1:0];
            div_cnt_in = '0;
            state_in   = fan_gov_pkg::ST_DIV;
         end
         fan_gov_pkg::ST_DIV: begin
            rem_in     = trial_ge ? CNT_W'(trial - {1'b0, fill_ff}) : trial[CNT_W-1:0];
            quot_in    = {quot_ff[TEMP_W-2:0], trial_ge};
            div_cnt_in = div_cnt_ff + DCNT_W'(1);
            if (div_cnt_ff == LAST_STEP) begin
               state_in = fan_gov_pkg::ST_DONE;
            end
         end
         fan_gov_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_changed_in = 1'b0;
               if (quot_ff > prev_avg_ff) begin
                  fall_streak_in = 2'd0;
                  held_duty_in   = fan_gov_pkg::duty_for({1'b0, quot_ff}, idle_duty_ff);
                  prev_avg_in    = quot_ff;
                  rsp_changed_in = 1'b1;
               end else if (quot_ff < prev_avg_ff) begin
                  // The first fall of a descent only records the new average.
                  fall_streak_in = streak_next;
                  if (streak_next >= 2'd2) begin
                     held_duty_in   = fan_gov_pkg::duty_for(avg_plus, idle_duty_ff);
                     fall_streak_in = 2'd1;
                     rsp_changed_in = 1'b1;
                  end
                  prev_avg_in = quot_ff;
               end
               rsp_duty_in  = held_duty_in;
               rsp_valid_in = 1'b1;
               state_in     = fan_gov_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fan_gov_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fan_gov_pkg::ST_IDLE;
         idle_duty_ff   <= '0;
         write_slot_ff  <= '0;
         fill_ff        <= '0;
         prev_avg_ff    <= '0;
         fall_streak_ff <= '0;
         held_duty_ff   <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idle_duty_ff   <= idle_duty_in;
         write_slot_ff  <= write_slot_in;
         fill_ff        <= fill_in;
         prev_avg_ff    <= prev_avg_in;
         fall_streak_ff <= fall_streak_in;
         held_duty_ff   <= held_duty_in;
         rd_vld_ff      <= (state_ff == fan_gov_pkg::ST_READ);
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff      <= rd_cnt_in;
      sum_ff         <= sum_in;
      rem_ff         <= rem_in;
      quot_ff        <= quot_in;
      div_cnt_ff     <= div_cnt_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_duty_ff    <= rsp_duty_in;
   end

   `ASSERT_ALWAYS(a_fill_bounded, clock, reset, fill_ff <= FULL_CNT,
                  "fill count beyond window depth")
   `ASSERT_PROP(a_accept_reads, clock, reset,
                req_take |=> (state_ff == fan_gov_pkg::ST_READ && fill_ff != '0),
                "accepted item did not start a ring read")
   `ASSERT_ALWAYS(a_rem_below_fill, clock, reset,
                  (state_ff != fan_gov_pkg::ST_DIV) || (rem_ff < fill_ff),
                  "divider remainder not below the fill count")
   `ASSERT_ALWAYS(a_streak_small, clock, reset, fall_streak_ff <= 2'd1,
                  "fall streak left its reachable range")

endmodule

`default_nettype wire
